// ===== rtl/core/sfdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdm_pkg: shared constants and types for the stick filter / dead zone mapper
// Widths follow from the sample width; the divider request travels as a struct.
// ----------------------------------------------------------------------------
package sfdm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DEAD_BITS   = 12;
  localparam int SMOOTH_BITS = 7;
  localparam int VALUE_BITS  = 16;
  localparam int FRAC_BITS   = 8;

  // filter accumulator (fixed point, FRAC_BITS fraction) and its weighted sum
  localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
  localparam int NUM_W = ACC_W + SMOOTH_BITS;
  // rounded smoothed sample, one bit wider than the raw sample
  localparam int SM_W  = SAMPLE_BITS + 1;
  localparam int WMAX  = (SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS;
  // signed band edges and spans
  localparam int SP_W  = WMAX + 2;
  localparam int XW    = SAMPLE_BITS + 2;
  localparam int OD_W  = VALUE_BITS + 1;
  localparam int PR_W  = XW + OD_W;
  localparam int PM_W  = SAMPLE_BITS + VALUE_BITS;
  localparam int V_W   = PM_W + 2;

  // shared divider, two quotient bits per cycle
  localparam int DIV_N     = (PM_W > NUM_W) ? PM_W : NUM_W;
  localparam int DIV_STEPS = (DIV_N + 1) / 2;
  localparam int DIV_QW    = 2 * DIV_STEPS;
  localparam int DIV_D     = WMAX + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_BITS + SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [SMOOTH_BITS-1:0] SMOOTH_MAX = SMOOTH_BITS'(99);
  localparam logic [SMOOTH_BITS-1:0] PCT_FULL   = SMOOTH_BITS'(100);
  localparam logic [NUM_W-1:0]       ROUND_PCT  = NUM_W'(50);
  localparam logic [ACC_W:0]         ROUND_ACC  = (ACC_W + 1)'(1 << (FRAC_BITS - 1));
  localparam logic [ACC_W-1:0]       ACC_MAX    =
    ACC_W'(((1 << SAMPLE_BITS) - 1) << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DIV_QW-1:0] dividend;
    logic [DIV_D-1:0]  divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/stick_filter_deadzone_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stick_filter_deadzone_mapper: stick axis smoothing, dead zone and mapping
// One raw sample in, one mapped signed stick value out per item.
// ----------------------------------------------------------------------------
// One item at a time: a sample passes MULA, MULB, DIVF and SEL, then goes to
// DONE straight away when the smoothed sample lies inside the dead band or the
// half range has zero width, else through MULM, DIVS and DIVM. The sequencer
// is back in idle as the result is registered and takes the next sample there.
// The shared divider yields two quotient bits per cycle and runs once for the
// percent filter and, on the MULM path, once for the linear map. The result
// sits in an output register, so the next sample is taken while it waits; a
// further result is held back until that register frees. Configuration writes
// take effect at once and belong to idle periods only.
module stick_filter_deadzone_mapper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: raw_sample [11:0], zero pad above
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sfdm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata: stick_value [15:0], raw_echo [27:16], zero pad above
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sfdm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_wen,
  input  logic [sfdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfdm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MULA, S_MULB, S_DIVF, S_SEL, S_MULM, S_DIVS, S_DIVM, S_DONE
  } state_t;

  // configuration
  logic        [SAMPLE_BITS-1:0] raw_min_r, raw_center_r, raw_max_r;
  logic signed [VALUE_BITS-1:0]  out_min_r, out_center_r, out_max_r;
  logic        [DEAD_BITS-1:0]   dead_band_r;
  logic        [SMOOTH_BITS-1:0] smoothing_r;

  // item path
  state_t                        state_r;
  logic        [SAMPLE_BITS-1:0] sample_r;
  logic        [ACC_W-1:0]       acc_r;
  logic        [NUM_W-1:0]       num_r;
  logic signed [XW-1:0]          x_r;
  logic signed [OD_W-1:0]        b_r;
  logic signed [SP_W-1:0]        den_r;
  logic signed [VALUE_BITS-1:0]  base_r, lo_r, hi_r;
  logic signed [PR_W-1:0]        prod_r;
  logic                          neg_r;
  logic signed [V_W-1:0]         v_r;
  div_req_t                      div_req_r;
  logic                          out_valid_r;
  logic        [VALUE_BITS-1:0]  out_value_r;
  logic        [SAMPLE_BITS-1:0] out_echo_r;

  logic                          div_done;
  logic        [DIV_QW-1:0]      div_quo;

  sfdm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_min_r    <= '0;
      raw_center_r <= SAMPLE_BITS'(2048);
      raw_max_r    <= SAMPLE_BITS'(4095);
      out_min_r    <= -VALUE_BITS'(500);
      out_center_r <= '0;
      out_max_r    <= VALUE_BITS'(500);
      dead_band_r  <= '0;
      smoothing_r  <= SMOOTH_BITS'(30);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_RAW_MIN:    raw_min_r    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RAW_CENTER: raw_center_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RAW_MAX:    raw_max_r    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_OUT_MIN:    out_min_r    <= $signed(cfg_data[VALUE_BITS-1:0]);
        CFG_OUT_CENTER: out_center_r <= $signed(cfg_data[VALUE_BITS-1:0]);
        CFG_OUT_MAX:    out_max_r    <= $signed(cfg_data[VALUE_BITS-1:0]);
        CFG_DEAD_BAND:  dead_band_r  <= cfg_data[DEAD_BITS-1:0];
        CFG_SMOOTHING:  smoothing_r  <= cfg_data[SMOOTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- filter arithmetic ----------------
  logic [SMOOTH_BITS-1:0] k_w, kc_w;
  logic [NUM_W-1:0]       mul_old, mul_new, num_sum;
  logic [ACC_W:0]         acc_rnd;
  logic [SM_W-1:0]        s_w;

  assign k_w     = (smoothing_r > SMOOTH_MAX) ? SMOOTH_MAX : smoothing_r;
  assign kc_w    = PCT_FULL - k_w;
  assign mul_old = NUM_W'(k_w) * NUM_W'(acc_r);
  assign mul_new = NUM_W'(kc_w) * NUM_W'({sample_r, {FRAC_BITS{1'b0}}});
  assign num_sum = num_r + mul_new + ROUND_PCT;
  assign acc_rnd = {1'b0, acc_r} + ROUND_ACC;
  assign s_w     = acc_rnd[ACC_W:FRAC_BITS];

  // ---------------- band selection ----------------
  logic signed [SP_W-1:0] s_sx, hi_start, lo_end, rmin_sx, rmax_sx;
  logic signed [SP_W-1:0] den_hi, den_lo;
  logic                   above, below;

  assign s_sx     = $signed(SP_W'(s_w));
  assign rmin_sx  = $signed(SP_W'(raw_min_r));
  assign rmax_sx  = $signed(SP_W'(raw_max_r));
  assign hi_start = $signed(SP_W'(raw_center_r)) + $signed(SP_W'(dead_band_r));
  assign lo_end   = $signed(SP_W'(raw_center_r)) - $signed(SP_W'(dead_band_r));
  assign above    = s_sx > hi_start;
  assign below    = s_sx < lo_end;
  assign den_hi   = rmax_sx - hi_start;
  assign den_lo   = lo_end - rmin_sx;

  // ---------------- map arithmetic ----------------
  logic signed [PR_W-1:0]   prod_abs;
  logic signed [SP_W-1:0]   den_abs;
  logic        [PM_W-1:0]   q_mag;
  logic signed [PM_W:0]     q_s;
  logic signed [V_W-1:0]    v_map, lo_x, hi_x;
  logic        [VALUE_BITS-1:0] clamp_w;
  logic                     out_free;

  assign prod_abs = prod_r[PR_W-1] ? -prod_r : prod_r;
  assign den_abs  = den_r[SP_W-1] ? -den_r : den_r;
  assign q_mag    = div_quo[PM_W-1:0];
  assign q_s      = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign v_map    = V_W'(q_s) + V_W'(base_r);
  assign lo_x     = V_W'(lo_r);
  assign hi_x     = V_W'(hi_r);

  // lower bound is checked first; with inverted bounds a value below it gets lo_r, any other gets hi_r
  always_comb begin
    if (v_r < lo_x) begin
      clamp_w = lo_r;
    end else if (v_r > hi_x) begin
      clamp_w = hi_r;
    end else begin
      clamp_w = v_r[VALUE_BITS-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      acc_r           <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= (state_r == S_MULB) || (state_r == S_DIVS);
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata[SAMPLE_BITS-1:0];
            state_r  <= S_MULA;
          end
        end
        S_MULA: begin
          num_r   <= mul_old;
          state_r <= S_MULB;
        end
        S_MULB: begin
          div_req_r.dividend <= DIV_QW'(num_sum);
          div_req_r.divisor  <= DIV_D'(PCT_FULL);
          state_r            <= S_DIVF;
        end
        S_DIVF: begin
          if (div_done) begin
            acc_r   <= div_quo[ACC_W-1:0];
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          if (above) begin
            x_r    <= XW'(s_sx - hi_start);
            b_r    <= OD_W'(out_max_r) - OD_W'(out_center_r);
            den_r  <= den_hi;
            base_r <= out_center_r;
            lo_r   <= out_center_r;
            hi_r   <= out_max_r;
            v_r    <= V_W'(out_max_r);
            state_r <= (den_hi == '0) ? S_DONE : S_MULM;
          end else if (below) begin
            x_r    <= XW'(s_sx - rmin_sx);
            b_r    <= OD_W'(out_center_r) - OD_W'(out_min_r);
            den_r  <= den_lo;
            base_r <= out_min_r;
            lo_r   <= out_min_r;
            hi_r   <= out_center_r;
            v_r    <= V_W'(out_min_r);
            state_r <= (den_lo == '0) ? S_DONE : S_MULM;
          end else begin
            lo_r    <= out_center_r;
            hi_r    <= out_center_r;
            v_r     <= V_W'(out_center_r);
            state_r <= S_DONE;
          end
        end
        S_MULM: begin
          prod_r  <= PR_W'(x_r) * PR_W'(b_r);
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          div_req_r.dividend <= DIV_QW'(prod_abs[PM_W-1:0]);
          div_req_r.divisor  <= den_abs[DIV_D-1:0];
          neg_r              <= prod_r[PR_W-1] ^ den_r[SP_W-1];
          state_r            <= S_DIVM;
        end
        S_DIVM: begin
          if (div_done) begin
            v_r     <= v_map;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_value_r <= clamp_w;
            out_echo_r  <= sample_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_echo_r, out_value_r});

  // ---------------- checks ----------------
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ACC_MAX)
    else $error("filter accumulator above full-scale sample");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVF || state_r == S_DIVM))
    else $error("divider finished while sequencer not waiting on it");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in flight");

endmodule
`default_nettype wire

// ===== rtl/core/sfdm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfdm_divider: unsigned restoring divider
// Shifts the dividend out two bits per cycle; quotient bits shift in behind.
// ----------------------------------------------------------------------------
module sfdm_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfdm_pkg::div_req_t            req,
  output logic                          done,
  output logic [sfdm_pkg::DIV_QW-1:0]   quotient
);
  import sfdm_pkg::*;

  logic [DIV_QW-1:0] work_r, work_nxt;
  logic [DIV_D-1:0]  rem_r, rem_nxt;
  logic [DIV_D-1:0]  dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  always_comb begin
    logic [DIV_D:0] trial;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_nxt, work_nxt[DIV_QW-1]};
      work_nxt = {work_nxt[DIV_QW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt     = DIV_D'(trial - {1'b0, dvs_r});
        work_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DIV_D-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule
`default_nettype wire
